>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants and types for the pressure and temperature compensation
// pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int unsigned COEF_W = 48;
	localparam int unsigned RAW_W = 20;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_index_t;

	localparam logic [63:0] TEMP_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [20:0] PRESS_BASE = 21'd1048576;
	localparam logic [63:0] P1_BIAS = 64'h0000_8000_0000_0000;

	localparam int unsigned TEMP_LAT = 4;
	localparam int unsigned MUL_LAT = 2;
	localparam int unsigned DIV_LAT = 64;
	localparam int unsigned TOTAL_LAT = 84;

endpackage

>>> rtl/ptc_delay.sv
// ----------------------------------------------------------------------------
// ptc_delay
// Fixed-length register delay line used to align operands across stages.
// ----------------------------------------------------------------------------
module ptc_delay #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		line_q[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			line_q[i] <= line_q[i-1];
		end
	end

	assign dout = line_q[DEPTH-1];
endmodule

>>> rtl/ptc_mul64.sv
// ----------------------------------------------------------------------------
// ptc_mul64
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product.
// ----------------------------------------------------------------------------
module ptc_mul64 (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;
	logic [63:0] lh_full;
	logic [63:0] hl_full;

	// Only the low halves of the cross products reach the low 64 bits.
	assign lh_full = a[31:0] * b[63:32];
	assign hl_full = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= lh_full[31:0];
		hl_s1 <= hl_full[31:0];
		p_s2 <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
	end

	assign p = p_s2;
endmodule

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider: 64-bit magnitude by 31-bit magnitude, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div
	import ptc_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] dividend,
	input  logic [30:0] divisor,
	output logic [63:0] quotient
);
	logic [63:0] word_s [DIV_LAT+1];
	logic [31:0] rem_s  [DIV_LAT+1];
	logic [30:0] dvs_s  [DIV_LAT+1];

	assign word_s[0] = dividend;
	assign rem_s[0] = 32'd0;
	assign dvs_s[0] = divisor;

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [31:0] trial;
		logic        ge;
		assign trial = {rem_s[k][30:0], word_s[k][63]};
		assign ge = trial >= {1'b0, dvs_s[k]};
		always_ff @(posedge clk) begin
			word_s[k+1] <= {word_s[k][62:0], ge};
			rem_s[k+1] <= ge ? trial - {1'b0, dvs_s[k]} : trial;
			dvs_s[k+1] <= dvs_s[k];
		end
	end

	assign quotient = word_s[DIV_LAT];
endmodule

>>> rtl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Four-stage temperature compensation in 32-bit wrapping arithmetic.
// ----------------------------------------------------------------------------
module ptc_temp
	import ptc_pkg::*;
(
	input  logic                clk,
	input  logic [RAW_W-1:0]    temp_raw,
	input  logic [COEF_W-1:0]   coeffs,
	output logic [31:0]         fine_full,
	output logic signed [17:0]  centi_sat,
	output logic signed [23:0]  fine_sat
);
	logic [15:0]        t1;
	logic signed [15:0] t2;
	logic signed [15:0] t3;
	logic signed [17:0] x;
	logic signed [16:0] d;
	logic signed [33:0] xa;
	logic signed [33:0] dd;
	logic signed [35:0] bt;
	logic [31:0]        pa_s1;
	logic [31:0]        dd_s1;
	logic [31:0]        a_s2;
	logic [31:0]        b_s2;
	logic [31:0]        tf_s3;
	logic [31:0]        tf5;
	logic signed [23:0] tc;
	logic [31:0]        tf_s4;
	logic signed [17:0] tc_s4;
	logic signed [23:0] tfs_s4;

	assign t1 = coeffs[15:0];
	assign t2 = coeffs[31:16];
	assign t3 = coeffs[47:32];
	assign x = $signed({1'b0, temp_raw[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d = $signed({1'b0, temp_raw[19:4]}) - $signed({1'b0, t1});
	assign xa = x * t2;
	assign dd = d * d;
	assign bt = $signed(dd_s1[31:12]) * t3;
	assign tf5 = {tf_s3[29:0], 2'b00} + tf_s3 + 32'd128;
	assign tc = $signed(tf5[31:8]);

	always_ff @(posedge clk) begin
		pa_s1 <= xa[31:0];
		dd_s1 <= dd[31:0];
		a_s2 <= 32'($signed(pa_s1) >>> 11);
		b_s2 <= bt[31:0];
		tf_s3 <= a_s2 + 32'($signed(b_s2) >>> 14);
		tf_s4 <= tf_s3;
		if (tc > 24'sd131071) begin
			tc_s4 <= 18'sd131071;
		end else if (tc < -24'sd131072) begin
			tc_s4 <= -18'sd131072;
		end else begin
			tc_s4 <= tc[17:0];
		end
		if ($signed(tf_s3) > 32'sd8388607) begin
			tfs_s4 <= 24'sd8388607;
		end else if ($signed(tf_s3) < -32'sd8388608) begin
			tfs_s4 <= -24'sd8388608;
		end else begin
			tfs_s4 <= tf_s3[23:0];
		end
	end

	assign fine_full = tf_s4;
	assign centi_sat = tc_s4;
	assign fine_sat = tfs_s4;
endmodule

>>> rtl/pressure_temperature_compensation.sv
// Throughput: one transaction per cycle; busy is never raised.
// The 64-stage divider sets most of the latency.
// Reset clears only the valid pipeline and the coefficient registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer temperature and pressure compensation with calibration registers,
// fully pipelined with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation
	import ptc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        temp_raw,
	input  logic [19:0]        pressure_raw,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [47:0]        wr_data,
	output logic               done,
	output logic signed [17:0] temperature_centi,
	output logic signed [23:0] fine_temperature,
	output logic [31:0]        pressure_q24_8,
	output logic               pressure_invalid
);
	logic [47:0] temp_coeffs_q;
	logic [47:0] press_a_q;
	logic [47:0] press_b_q;
	logic [47:0] press_c_q;
	logic [TOTAL_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start};
			if (wr_en) begin
				case (reg_index_t'(wr_index))
					REG_TEMP:    temp_coeffs_q <= wr_data;
					REG_PRESS_A: press_a_q <= wr_data;
					REG_PRESS_B: press_b_q <= wr_data;
					REG_PRESS_C: press_c_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[TOTAL_LAT-1];

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign p1 = {48'd0, press_a_q[15:0]};
	assign p2 = {{48{press_a_q[31]}}, press_a_q[31:16]};
	assign p3 = {{48{press_a_q[47]}}, press_a_q[47:32]};
	assign p4 = {{48{press_b_q[15]}}, press_b_q[15:0]};
	assign p5 = {{48{press_b_q[31]}}, press_b_q[31:16]};
	assign p6 = {{48{press_b_q[47]}}, press_b_q[47:32]};
	assign p7 = {{48{press_c_q[15]}}, press_c_q[15:0]};
	assign p8 = {{48{press_c_q[31]}}, press_c_q[31:16]};
	assign p9 = {{48{press_c_q[47]}}, press_c_q[47:32]};

	// Temperature section.
	logic [31:0]        tf;
	logic signed [17:0] tc_sat;
	logic signed [23:0] tf_sat;
	logic [41:0]        temp_out;

	ptc_temp u_temp (
		.clk      (clk),
		.temp_raw (temp_raw),
		.coeffs   (temp_coeffs_q),
		.fine_full(tf),
		.centi_sat(tc_sat),
		.fine_sat (tf_sat)
	);

	ptc_delay #(.WIDTH(42), .DEPTH(78)) u_dly_temp (
		.clk (clk),
		.din ({tc_sat, tf_sat}),
		.dout(temp_out)
	);

	// Pressure section: divisor and dividend terms.
	logic [63:0] v1, sq, q5, q2, r6, r3, q5_d, q2_d;
	logic [19:0] praw_d;

	assign v1 = {{32{tf[31]}}, tf} - TEMP_OFFSET;

	ptc_mul64 u_m_sq (.clk(clk), .a(v1), .b(v1), .p(sq));
	ptc_mul64 u_m_p5 (.clk(clk), .a(v1), .b(p5), .p(q5));
	ptc_mul64 u_m_p2 (.clk(clk), .a(v1), .b(p2), .p(q2));
	ptc_mul64 u_m_p6 (.clk(clk), .a(sq), .b(p6), .p(r6));
	ptc_mul64 u_m_p3 (.clk(clk), .a(sq), .b(p3), .p(r3));

	ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_q5 (.clk(clk), .din(q5), .dout(q5_d));
	ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_q2 (.clk(clk), .din(q2), .dout(q2_d));
	ptc_delay #(.WIDTH(20), .DEPTH(9)) u_dly_praw (
		.clk (clk),
		.din (pressure_raw),
		.dout(praw_d)
	);

	logic [63:0] v2_s9, e_s9, num_s10, e_s10, m6, m7;
	logic [20:0] pdiff;

	assign pdiff = PRESS_BASE - {1'b0, praw_d};

	always_ff @(posedge clk) begin
		v2_s9 <= r6 + {q5_d[46:0], 17'd0} + {p4[28:0], 35'd0};
		e_s9 <= P1_BIAS + 64'($signed(r3) >>> 8) + {q2_d[51:0], 12'd0};
		num_s10 <= {12'd0, pdiff, 31'd0} - v2_s9;
		e_s10 <= e_s9;
	end

	ptc_mul64 u_m_p1 (.clk(clk), .a(e_s10), .b(p1), .p(m6));
	ptc_mul64 u_m_sc (.clk(clk), .a(num_s10), .b(PRESS_SCALE), .p(m7));

	// Sign and magnitude ahead of the unsigned divider.
	logic [30:0] dv;
	logic [63:0] ma_s13, qraw, q_s78;
	logic [30:0] mb_s13;
	logic        neg_s13, zero_s13, neg_d, zero_d;

	assign dv = m6[63:33];

	always_ff @(posedge clk) begin
		ma_s13 <= m7[63] ? 64'd0 - m7 : m7;
		mb_s13 <= dv[30] ? 31'd0 - dv : dv;
		neg_s13 <= m7[63] ^ dv[30];
		zero_s13 <= dv == 31'd0;
	end

	ptc_div u_div (
		.clk     (clk),
		.dividend(ma_s13),
		.divisor (mb_s13),
		.quotient(qraw)
	);

	ptc_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_dly_neg (
		.clk (clk),
		.din (neg_s13),
		.dout(neg_d)
	);
	ptc_delay #(.WIDTH(1), .DEPTH(69)) u_dly_zero (
		.clk (clk),
		.din (zero_s13),
		.dout(zero_d)
	);

	always_ff @(posedge clk) begin
		q_s78 <= neg_d ? 64'd0 - qraw : qraw;
	end

	// Second-order pressure correction.
	logic [63:0] ps, w2, pss, w1, w2_d, q_d;

	assign ps = 64'($signed(q_s78) >>> 13);

	ptc_mul64 u_m_p8 (.clk(clk), .a(q_s78), .b(p8), .p(w2));
	ptc_mul64 u_m_ps (.clk(clk), .a(ps), .b(ps), .p(pss));
	ptc_mul64 u_m_p9 (.clk(clk), .a(pss), .b(p9), .p(w1));

	ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_w2 (.clk(clk), .din(w2), .dout(w2_d));
	ptc_delay #(.WIDTH(64), .DEPTH(2 * MUL_LAT)) u_dly_q (
		.clk (clk),
		.din (q_s78),
		.dout(q_d)
	);

	logic [63:0] sum_s83, pf;
	logic        zero_s83;
	logic [41:0] temp_s83;
	logic [31:0] press_s84;
	logic        inv_s84;
	logic [41:0] temp_s84;

	assign pf = 64'($signed(sum_s83) >>> 8) + {p7[59:0], 4'd0};

	always_ff @(posedge clk) begin
		sum_s83 <= q_d + 64'($signed(w1) >>> 25) + 64'($signed(w2_d) >>> 19);
		zero_s83 <= zero_d;
		temp_s83 <= temp_out;
		temp_s84 <= temp_s83;
		inv_s84 <= zero_s83;
		if (zero_s83 || pf[63]) begin
			press_s84 <= 32'd0;
		end else if (|pf[62:32]) begin
			press_s84 <= 32'hFFFF_FFFF;
		end else begin
			press_s84 <= pf[31:0];
		end
	end

	assign temperature_centi = temp_s84[41:24];
	assign fine_temperature = temp_s84[23:0];
	assign pressure_q24_8 = press_s84;
	assign pressure_invalid = inv_s84;
endmodule
